### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the bit reader RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define EGBR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EGBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/egbr_pkg.sv
// ----------------------------------------------------------------------------
// egbr_pkg
// Types and fixed constants shared by the Exp-Golomb bit reader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package egbr_pkg;

   // command codes
   localparam logic [2:0] CMD_LOAD  = 3'd0;
   localparam logic [2:0] CMD_RAW   = 3'd1;
   localparam logic [2:0] CMD_UE    = 3'd2;
   localparam logic [2:0] CMD_SE    = 3'd3;
   localparam logic [2:0] CMD_START = 3'd4;

   // longest raw read and longest zero prefix
   localparam logic [5:0] MAX_CODE_BITS = 6'd32;

   // bytes fetched into the window per read kind
   localparam logic [3:0] RAW_FETCH_BYTES = 4'd5;
   localparam logic [3:0] UE_FETCH_BYTES  = 4'd9;

   localparam int unsigned WIN_W = 72;
   localparam int unsigned ALN_W = 64;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data_byte;
      logic [5:0] bit_count;
   } req_type;

   typedef struct packed {
      logic [31:0]        value;
      logic signed [31:0] signed_value;
      logic               error;
      logic [15:0]        bit_position;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic fetch;
      logic align;
      logic lz_step;
      logic extract;
      logic finish;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic read_go;
      logic fetch_done;
      logic lz_done;
      logic is_raw;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/core/exp_golomb_bit_reader.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_reader
// Load, start, unused codes and reads refused up front go from exec straight
// to the strobe; raw reads fetch, align and extract, ue/se also count zeros.
// A new beat is taken in the idle cycle after the strobe, never while one is
// still in flight; the byte fetch (one byte per cycle from the
// single-port byte store, 5 bytes raw, 9 bytes ue/se) sets the read time.
// Synchronous reset clears counters, error flag and sequencer; store is kept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

// MSB-first bitstream reader with Exp-Golomb ue(v)/se(v) decode.
//
// Beats: start with busy low accepts req_payload. Exactly one result per
// beat, shown on rsp_payload for the single cycle rsp_strobe is high; the
// receiver cannot stall it.
//
// Flow per read:
//   exec    - precheck (sticky error, raw count range, bits left), load/start
//   fetch   - bytes from cursor byte into a 72-bit window
//   align   - shift out the cursor's bit offset
//   lzc     - zero prefix counted a byte per cycle, up to 32
//   extract - left-justify the field (raw at cursor, ue at marker bit)
//   finish  - right-align, ue/se mapping, cursor and error update
// The error flag is sticky until a start command; while set, reads return 0.

module exp_golomb_bit_reader
   import egbr_pkg::*;
#(
   parameter int unsigned BUF_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   egbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // store, counters, window and extraction
   egbr_datapath #(
      .BUF_BYTES (BUF_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // a result reported with the error flag must carry zero values
   `EGBR_ASSERT(a_error_zero_result, clock, reset, !(rsp_strobe && rsp_payload.error) || ((rsp_payload.value == 32'd0) && (rsp_payload.signed_value == 32'sd0)), "nonzero result with error set")

endmodule

`default_nettype wire

### rtl/core/egbr_ctrl.sv
// ----------------------------------------------------------------------------
// egbr_ctrl
// Sequencer for the bit reader: walks each read through exec, fetch, align,
// leading-zero count (ue/se only), extract and finish, then strobes the result; other beats go from exec to the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module egbr_ctrl
   import egbr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_EXEC    = 8'b0000_0010,
      S_FETCH   = 8'b0000_0100,
      S_ALIGN   = 8'b0000_1000,
      S_LZC     = 8'b0001_0000,
      S_EXTRACT = 8'b0010_0000,
      S_FINISH  = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = status.read_go ? S_FETCH : S_RESP;
         end
         S_FETCH: begin
            if (status.fetch_done) state_in = S_ALIGN;
         end
         S_ALIGN: begin
            state_in = status.is_raw ? S_EXTRACT : S_LZC;
         end
         S_LZC: begin
            if (status.lz_done) state_in = S_EXTRACT;
         end
         S_EXTRACT: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.capture = (state_ff == S_IDLE) && start;
      cmd.exec    = (state_ff == S_EXEC);
      cmd.fetch   = (state_ff == S_FETCH);
      cmd.align   = (state_ff == S_ALIGN);
      cmd.lz_step = (state_ff == S_LZC);
      cmd.extract = (state_ff == S_EXTRACT);
      cmd.finish  = (state_ff == S_FINISH);
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

`default_nettype wire

### rtl/core/egbr_datapath.sv
// ----------------------------------------------------------------------------
// egbr_datapath
// Byte store, stream counters, fetch window, iterative leading-zero
// counter and bit extractor of the bit reader.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module egbr_datapath
   import egbr_pkg::*;
#(
   parameter int unsigned BUF_BYTES = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_payload,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output rsp_type       rsp_payload
);

   localparam int unsigned AW    = $clog2(BUF_BYTES);
   localparam int unsigned LB_W  = $clog2(BUF_BYTES + 1);
   localparam int unsigned CUR_W = LB_W + 3;
   localparam int unsigned FA_W  = $clog2(BUF_BYTES + 9);
   localparam logic [LB_W-1:0] BUF_FULL = LB_W'(BUF_BYTES);

   function automatic logic [2:0] lzc8(input logic [7:0] b);
      logic [2:0] n;
      logic       found;
      n     = 3'd0;
      found = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!found) begin
            if (b[i]) found = 1'b1;
            else      n = 3'(n + 3'd1);
         end
      end
      return n;
   endfunction

   logic [7:0] mem [BUF_BYTES];

   req_type          req_ff,     req_in;
   logic [LB_W-1:0]  loaded_ff,  loaded_in;
   logic [CUR_W-1:0] cursor_ff,  cursor_in;
   logic             sticky_ff,  sticky_in;
   logic [CUR_W-1:0] avail_ff,   avail_in;
   logic [WIN_W-1:0] win_ff,     win_in;
   logic [ALN_W-1:0] aln_ff,     aln_in;
   logic [31:0]      scan_ff,    scan_in;
   logic [5:0]       zcnt_ff,    zcnt_in;
   logic [5:0]       z_ff,       z_in;
   logic [31:0]      ext_ff,     ext_in;
   logic [31:0]      value_ff,   value_in;
   logic [31:0]      sval_ff,    sval_in;
   logic [3:0]       issue_ff,   issue_in;
   logic [3:0]       recv_ff,    recv_in;
   logic             rvalid_ff,  rvalid_in;
   logic [7:0]       rdata_ff;
   logic             rbeyond_ff;

   logic             mem_we;
   logic [CUR_W-1:0] end_bits;
   logic [CUR_W-1:0] avail_c;
   logic             is_raw;
   logic             raw_fail;
   logic [3:0]       need;
   logic             rd_en;
   logic [FA_W-1:0]  fa;
   logic             fetch_beyond;
   logic [WIN_W-1:0] align_src;
   logic [WIN_W-1:0] align_shl;
   logic [7:0]       top_byte;
   logic             lz_done;
   logic [5:0]       ext_sh;
   logic [ALN_W-1:0] ext_shl;
   logic [5:0]       fin_n;
   logic [5:0]       fin_sh;
   logic [31:0]      fin_x;
   logic [31:0]      half;
   logic [31:0]      neg_half;
   logic [CUR_W-1:0] z_ext;
   logic [6:0]       two_z1;

   assign end_bits = {loaded_ff, 3'b000};
   assign avail_c  = end_bits - cursor_ff;
   assign is_raw   = (req_ff.command == CMD_RAW);
   assign raw_fail = sticky_ff || (req_ff.bit_count == 6'd0) ||
                     (req_ff.bit_count > MAX_CODE_BITS) ||
                     (avail_c < CUR_W'(req_ff.bit_count));

   // fetch: one byte address per cycle from the byte holding the cursor
   assign need         = is_raw ? RAW_FETCH_BYTES : UE_FETCH_BYTES;
   assign rd_en        = cmd.fetch && (issue_ff < need);
   assign fa           = FA_W'(cursor_ff[CUR_W-1:3]) + FA_W'(issue_ff);
   assign fetch_beyond = (fa >= FA_W'(loaded_ff));

   // raw window holds 5 bytes in the low end; left-justify before the shift
   assign align_src = is_raw ? {win_ff[39:0], 32'd0} : win_ff;
   assign align_shl = align_src << cursor_ff[2:0];

   assign top_byte = scan_ff[31:24];
   assign lz_done  = (zcnt_ff == MAX_CODE_BITS) || (top_byte != 8'd0);

   // raw: bits start at the cursor; ue: start at the marker bit
   assign ext_sh  = is_raw ? 6'd0 : z_ff;
   assign ext_shl = aln_ff << ext_sh;

   assign fin_n    = is_raw ? req_ff.bit_count : 6'(z_ff + 6'd1);
   assign fin_sh   = 6'(MAX_CODE_BITS - fin_n);
   assign fin_x    = ext_ff >> fin_sh;
   // marker + suffix = k + 1, so se maps straight from it
   assign half     = {1'b0, fin_x[31:1]};
   assign neg_half = 32'd0 - half;
   assign z_ext    = CUR_W'(z_ff);
   assign two_z1   = {z_ff, 1'b1};

   always_comb begin
      req_in    = req_ff;
      loaded_in = loaded_ff;
      cursor_in = cursor_ff;
      sticky_in = sticky_ff;
      avail_in  = avail_ff;
      win_in    = win_ff;
      aln_in    = aln_ff;
      scan_in   = scan_ff;
      zcnt_in   = zcnt_ff;
      z_in      = z_ff;
      ext_in    = ext_ff;
      value_in  = value_ff;
      sval_in   = sval_ff;
      issue_in  = issue_ff;
      recv_in   = recv_ff;
      rvalid_in = rd_en;
      mem_we    = 1'b0;

      if (cmd.capture) req_in = req_payload;

      if (cmd.exec) begin
         value_in = '0;
         sval_in  = '0;
         avail_in = avail_c;
         issue_in = '0;
         recv_in  = '0;
         case (req_ff.command)
            CMD_LOAD: begin
               if (loaded_ff != BUF_FULL) begin
                  mem_we    = 1'b1;
                  loaded_in = loaded_ff + LB_W'(1);
               end else begin
                  sticky_in = 1'b1;
               end
            end
            CMD_RAW: begin
               if (raw_fail) sticky_in = 1'b1;
            end
            CMD_START: begin
               loaded_in = '0;
               cursor_in = '0;
               sticky_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (rd_en) issue_in = issue_ff + 4'd1;

      if (rvalid_ff) begin
         win_in  = {win_ff[WIN_W-9:0], rbeyond_ff ? 8'd0 : rdata_ff};
         recv_in = recv_ff + 4'd1;
      end

      if (cmd.align) begin
         aln_in  = align_shl[WIN_W-1:WIN_W-ALN_W];
         scan_in = align_shl[WIN_W-1:WIN_W-32];
         zcnt_in = '0;
      end

      // one byte of the prefix per step
      if (cmd.lz_step) begin
         if (lz_done) begin
            z_in = (zcnt_ff == MAX_CODE_BITS) ? MAX_CODE_BITS :
                   6'(zcnt_ff + {3'b000, lzc8(top_byte)});
         end else begin
            scan_in = {scan_ff[23:0], 8'd0};
            zcnt_in = zcnt_ff + 6'd8;
         end
      end

      if (cmd.extract) ext_in = ext_shl[ALN_W-1:ALN_W-32];

      if (cmd.finish) begin
         if (is_raw) begin
            cursor_in = cursor_ff + CUR_W'(req_ff.bit_count);
            value_in  = fin_x;
         end else if ((z_ff == MAX_CODE_BITS) || (avail_ff <= z_ext)) begin
            // prefix ran off the end or hit the zero limit: zeros stay consumed
            sticky_in = 1'b1;
            cursor_in = cursor_ff + ((avail_ff <= z_ext) ? avail_ff : z_ext);
         end else if (avail_ff < CUR_W'(two_z1)) begin
            // suffix short: stop right after the marker
            sticky_in = 1'b1;
            cursor_in = cursor_ff + z_ext + CUR_W'(1);
         end else begin
            cursor_in = cursor_ff + CUR_W'(two_z1);
            if (req_ff.command == CMD_UE) value_in = fin_x - 32'd1;
            else                          sval_in  = fin_x[0] ? neg_half : half;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         cursor_ff <= '0;
         sticky_ff <= 1'b0;
         issue_ff  <= '0;
         recv_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         cursor_ff <= cursor_in;
         sticky_ff <= sticky_in;
         issue_ff  <= issue_in;
         recv_ff   <= recv_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      avail_ff <= avail_in;
      win_ff   <= win_in;
      aln_ff   <= aln_in;
      scan_ff  <= scan_in;
      zcnt_ff  <= zcnt_in;
      z_ff     <= z_in;
      ext_ff   <= ext_in;
      value_ff <= value_in;
      sval_ff  <= sval_in;
   end

   // byte store: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[loaded_ff[AW-1:0]] <= req_ff.data_byte;
      if (rd_en) begin
         rdata_ff   <= mem[fa[AW-1:0]];
         rbeyond_ff <= fetch_beyond;
      end
   end

   always_comb begin
      status            = '0;
      status.read_go    = (is_raw && !raw_fail) ||
                          (((req_ff.command == CMD_UE) || (req_ff.command == CMD_SE)) &&
                           !sticky_ff);
      status.fetch_done = (recv_ff == need);
      status.lz_done    = lz_done;
      status.is_raw     = is_raw;
   end

   always_comb begin
      rsp_payload              = '0;
      rsp_payload.value        = value_ff;
      rsp_payload.signed_value = $signed(sval_ff);
      rsp_payload.error        = sticky_ff;
      rsp_payload.bit_position = 16'(cursor_ff);
   end

   `EGBR_ASSERT(a_cursor_in_range, clock, reset, cursor_ff <= end_bits, "cursor past loaded end")
   `EGBR_ASSERT(a_loaded_in_range, clock, reset, loaded_ff <= BUF_FULL, "loaded count over capacity")
   `EGBR_ASSERT_NEXT(a_cursor_hold, clock, reset, !cmd.exec && !cmd.finish, $stable(cursor_ff), "cursor moved outside update steps")

endmodule

`default_nettype wire
